// ===== sv/assert_macros.svh =====
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// checked only while reset is released
`define ASSERT_RST(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`else

`define ASSERT_RST(lbl, clk_s, rstn_s, prop, msg)
`define ASSERT_ALWAYS(lbl, clk_s, prop, msg)

`endif

`endif

// ===== sv/pci_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pci_pkg;

  // sizes
  localparam int CHANNELS    = 6;
  localparam int SAMPLE_BITS = 16;
  localparam int CH_W        = 3;
  localparam int CH_IDX_W    = $clog2(CHANNELS);
  localparam int COEF_W      = 16;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int ERR_W       = SAMPLE_BITS + 1;
  localparam int DELTA_W     = SAMPLE_BITS + 2;
  localparam int SUM_W       = 32;
  localparam int MUL_A_W     = (SUM_W > COEF_W + DELTA_W) ? SUM_W : COEF_W + DELTA_W;
  localparam int MUL_B_W     = COEF_W + 1;
  localparam int PROD_W      = MUL_A_W + MUL_B_W;
  localparam int ACC_W       = 49;
  localparam int SUM_LIM_EXP = 46;
  localparam int D_FRAC      = 8;
  localparam int THR_FRAC    = 12;
  localparam int RAT_W       = COEF_W + SAMPLE_BITS + 1;
  localparam int SPLIT       = 24;
  localparam int RND_W       = SPLIT + COEF_W + 1;
  localparam int RES_LO_W    = RND_W - SPLIT;
  localparam int PROG_LEN    = 8;
  localparam int PC_W        = $clog2(PROG_LEN);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_PERIOD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO_THR  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_SCALE  = 3'd5;

  // register reset values
  localparam logic [CFG_W-1:0] RST_PROP_GAIN  = 16'd256;
  localparam logic [CFG_W-1:0] RST_INTEG_GAIN = 16'd0;
  localparam logic [CFG_W-1:0] RST_DERIV_GAIN = 16'd0;
  localparam logic [CFG_W-1:0] RST_INV_PERIOD = 16'd256;
  localparam logic [CFG_W-1:0] RST_RATIO_THR  = 16'd4096;
  localparam logic [CFG_W-1:0] RST_OUT_SCALE  = 16'd65535;

  typedef struct packed {
    logic signed [COEF_W-1:0] prop_gain;
    logic signed [COEF_W-1:0] integ_gain;
    logic signed [COEF_W-1:0] deriv_gain;
    logic        [COEF_W-1:0] inv_sample_period;
    logic signed [COEF_W-1:0] ratio_threshold;
    logic        [COEF_W-1:0] output_scale;
  } cfg_t;

  typedef enum logic [2:0] {
    A_ERR, A_SUM, A_DELTA, A_PROD, A_SETP, A_ACC_LO, A_ACC_HI
  } a_sel_t;

  typedef enum logic [2:0] {
    B_PGAIN, B_IGAIN, B_DGAIN, B_INV, B_THR, B_SCALE
  } b_sel_t;

  typedef enum logic [1:0] {
    ACC_NOP, ACC_LOAD, ACC_ADD, ACC_ADD_SAT
  } acc_op_t;

  typedef enum logic [1:0] {
    X_NONE, X_RATIO, X_ROUND, X_FINISH
  } aux_op_t;

  typedef enum logic {
    COND_NEVER, COND_DGAIN_ZERO
  } cond_t;

  typedef struct packed {
    a_sel_t            a_sel;
    b_sel_t            b_sel;
    logic              mul_en;
    acc_op_t           acc_op;
    aux_op_t           aux_op;
    cond_t             cond;
    logic [PC_W-1:0]   target;
    logic              last;
  } ctrl_word_t;

  typedef struct packed {
    logic [CH_W-1:0]               channel_out;
    logic signed [SAMPLE_BITS-1:0] drive;
    logic                          clipped;
  } res_t;

  typedef struct packed {
    logic                    en;
    logic [CH_IDX_W-1:0]     ch;
    logic signed [SUM_W-1:0] sum;
    logic signed [ERR_W-1:0] err;
  } st_wr_t;

  // microprogram: one control word per step
  function automatic ctrl_word_t ucode(input logic [PC_W-1:0] pc);
    ctrl_word_t w;
    w = '0;
    unique case (pc)
      3'd0: begin
        w.a_sel = A_ERR;    w.b_sel = B_PGAIN; w.mul_en = 1'b1;
      end
      3'd1: begin
        w.a_sel = A_SUM;    w.b_sel = B_IGAIN; w.mul_en = 1'b1;
        w.acc_op = ACC_LOAD;
      end
      3'd2: begin
        w.a_sel = A_DELTA;  w.b_sel = B_DGAIN; w.mul_en = 1'b1;
        w.acc_op = ACC_ADD;
        w.cond = COND_DGAIN_ZERO; w.target = 3'd4;
      end
      3'd3: begin
        w.a_sel = A_PROD;   w.b_sel = B_INV;   w.mul_en = 1'b1;
      end
      3'd4: begin
        w.a_sel = A_SETP;   w.b_sel = B_THR;   w.mul_en = 1'b1;
        w.acc_op = ACC_ADD_SAT;
      end
      3'd5: begin
        w.a_sel = A_ACC_LO; w.b_sel = B_SCALE; w.mul_en = 1'b1;
        w.aux_op = X_RATIO;
      end
      3'd6: begin
        w.a_sel = A_ACC_HI; w.b_sel = B_SCALE; w.mul_en = 1'b1;
        w.aux_op = X_ROUND;
      end
      3'd7: begin
        w.aux_op = X_FINISH; w.last = 1'b1;
      end
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== sv/pci_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface pci_in_if;
  import pci_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [CH_W-1:0]               channel;
  logic signed [SAMPLE_BITS-1:0] setpoint;
  logic signed [SAMPLE_BITS-1:0] measured;

  modport source (output valid, output channel, output setpoint, output measured,
                  input ready);
  modport sink   (input valid, input channel, input setpoint, input measured,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/pci_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface pci_out_if;
  import pci_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [CH_W-1:0]               channel_out;
  logic signed [SAMPLE_BITS-1:0] drive;
  logic                          clipped;

  modport source (output valid, output channel_out, output drive, output clipped,
                  input ready);
  modport sink   (input valid, input channel_out, input drive, input clipped,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/pci_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pci_sequencer (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  input  wire                  dgain_zero,
  input  wire                  out_free,
  output pci_pkg::ctrl_word_t  ctrl,
  output logic                 step_en,
  output logic                 busy
);
  import pci_pkg::*;

  logic [PC_W-1:0] pc_r, pc_nxt;
  logic            busy_r, busy_nxt;
  logic            jump;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= '0;
      busy_r <= 1'b0;
    end else begin
      pc_r   <= pc_nxt;
      busy_r <= busy_nxt;
    end
  end

  always_comb begin
    ctrl     = ucode(pc_r);
    // final step waits while the result register is still occupied
    step_en  = busy_r && !(ctrl.last && !out_free);
    jump     = (ctrl.cond == COND_DGAIN_ZERO) && dgain_zero;
    pc_nxt   = pc_r;
    busy_nxt = busy_r;
    if (!busy_r) begin
      pc_nxt   = '0;
      busy_nxt = start;
    end else if (step_en) begin
      if (ctrl.last) begin
        pc_nxt   = '0;
        busy_nxt = 1'b0;
      end else if (jump) begin
        pc_nxt = ctrl.target;
      end else begin
        pc_nxt = pc_r + PC_W'(1);
      end
    end
  end

  assign busy = busy_r;

  `ASSERT_RST(a_idle_pc_zero, clk, rst_n, !busy_r |-> pc_r == '0, "step counter off origin while idle")
  `ASSERT_RST(a_last_ends, clk, rst_n, (step_en && ctrl.last) |=> !busy_r, "program did not end after last step")
  `ASSERT_RST(a_stall_holds, clk, rst_n, (busy_r && !step_en) |=> (busy_r && $stable(pc_r)), "stalled step moved")
  `ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !busy_r, "sequencer busy after reset")

endmodule

`default_nettype wire

// ===== sv/pci_loop_state.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pci_loop_state (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire [pci_pkg::CH_W-1:0]                rd_ch,
  output logic signed [pci_pkg::SUM_W-1:0]       rd_sum,
  output logic signed [pci_pkg::ERR_W-1:0]       rd_err,
  input  pci_pkg::st_wr_t                        wr
);
  import pci_pkg::*;

  logic signed [SUM_W-1:0] sum_r [CHANNELS];
  logic signed [ERR_W-1:0] err_r [CHANNELS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        sum_r[i] <= '0;
        err_r[i] <= '0;
      end
    end else if (wr.en) begin
      sum_r[wr.ch] <= wr.sum;
      err_r[wr.ch] <= wr.err;
    end
  end

  // out-of-range channels never start a program, read as zero
  always_comb begin
    if (rd_ch < CH_W'(CHANNELS)) begin
      rd_sum = sum_r[rd_ch[CH_IDX_W-1:0]];
      rd_err = err_r[rd_ch[CH_IDX_W-1:0]];
    end else begin
      rd_sum = '0;
      rd_err = '0;
    end
  end

endmodule

`default_nettype wire

// ===== sv/pci_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pci_datapath (
  input  wire                                     clk,
  input  wire                                     start,
  input  wire [pci_pkg::CH_W-1:0]                 in_channel,
  input  wire signed [pci_pkg::SAMPLE_BITS-1:0]   in_setpoint,
  input  wire signed [pci_pkg::SAMPLE_BITS-1:0]   in_measured,
  input  wire signed [pci_pkg::SUM_W-1:0]         rd_sum,
  input  wire signed [pci_pkg::ERR_W-1:0]         rd_err,
  input  pci_pkg::cfg_t                           cfg,
  input  pci_pkg::ctrl_word_t                     ctrl,
  input  wire                                     step_en,
  output pci_pkg::res_t                           res,
  output pci_pkg::st_wr_t                         st_wr
);
  import pci_pkg::*;

  localparam logic signed [ACC_W-1:0] SUM_LIM =
    {{(ACC_W-SUM_LIM_EXP-1){1'b0}}, 1'b1, {SUM_LIM_EXP{1'b0}}};
  localparam logic signed [ACC_W-1:0] SUM_LIM_N = -SUM_LIM;
  localparam logic signed [PROD_W-1:0] DRV_MAX =
    {{(PROD_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [PROD_W-1:0] DRV_MIN = -DRV_MAX - PROD_W'(1);
  localparam logic [RND_W-1:0] RND_HALF = {1'b1, {(SPLIT-1){1'b0}}};
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // operands captured on transfer
  logic [CH_W-1:0]               ch_r;
  logic signed [SAMPLE_BITS-1:0] sp_r;
  logic signed [ERR_W-1:0]       err_r;
  logic signed [DELTA_W-1:0]     delta_r;
  logic signed [SUM_W-1:0]       sum_r;

  // working registers
  logic signed [PROD_W-1:0]      prod_r, prod_nxt;
  logic signed [ACC_W-1:0]       acc_r, acc_nxt;
  logic                          below_r, below_nxt;
  logic [RES_LO_W-1:0]           rnd_r, rnd_nxt;

  logic signed [ERR_W-1:0]       err_in;
  logic signed [DELTA_W-1:0]     delta_in;
  logic signed [MUL_A_W-1:0]     mul_a;
  logic signed [MUL_B_W-1:0]     mul_b;
  logic signed [PROD_W-1:0]      d_sh;
  logic signed [ACC_W-1:0]       acc_tot;
  logic signed [RAT_W-1:0]       lhs, rhs;
  logic [RND_W-1:0]              rnd_sum;
  logic signed [PROD_W-1:0]      y;
  logic signed [SUM_W:0]         sum_ext;
  logic signed [SUM_W-1:0]       sum_new;
  logic                          integ_on;

  assign err_in   = {in_setpoint[SAMPLE_BITS-1], in_setpoint}
                  - {in_measured[SAMPLE_BITS-1], in_measured};
  assign delta_in = {err_in[ERR_W-1], err_in} - {rd_err[ERR_W-1], rd_err};

  always_ff @(posedge clk) begin
    if (start) begin
      ch_r    <= in_channel;
      sp_r    <= in_setpoint;
      err_r   <= err_in;
      delta_r <= delta_in;
      sum_r   <= rd_sum;
    end
    if (step_en) begin
      prod_r  <= prod_nxt;
      acc_r   <= acc_nxt;
      below_r <= below_nxt;
      rnd_r   <= rnd_nxt;
    end
  end

  // shared multiplier operand selection
  always_comb begin
    unique case (ctrl.a_sel)
      A_ERR:    mul_a = {{(MUL_A_W-ERR_W){err_r[ERR_W-1]}}, err_r};
      A_SUM:    mul_a = {{(MUL_A_W-SUM_W){sum_r[SUM_W-1]}}, sum_r};
      A_DELTA:  mul_a = {{(MUL_A_W-DELTA_W){delta_r[DELTA_W-1]}}, delta_r};
      A_PROD:   mul_a = prod_r[MUL_A_W-1:0];
      A_SETP:   mul_a = {{(MUL_A_W-SAMPLE_BITS){sp_r[SAMPLE_BITS-1]}}, sp_r};
      A_ACC_LO: mul_a = {{(MUL_A_W-SPLIT){1'b0}}, acc_r[SPLIT-1:0]};
      A_ACC_HI: mul_a = {{(MUL_A_W-SPLIT){acc_r[2*SPLIT-1]}}, acc_r[2*SPLIT-1:SPLIT]};
      default:  mul_a = '0;
    endcase
    unique case (ctrl.b_sel)
      B_PGAIN: mul_b = {cfg.prop_gain[COEF_W-1], cfg.prop_gain};
      B_IGAIN: mul_b = {cfg.integ_gain[COEF_W-1], cfg.integ_gain};
      B_DGAIN: mul_b = {cfg.deriv_gain[COEF_W-1], cfg.deriv_gain};
      B_INV:   mul_b = {1'b0, cfg.inv_sample_period};
      B_THR:   mul_b = {cfg.ratio_threshold[COEF_W-1], cfg.ratio_threshold};
      B_SCALE: mul_b = {1'b0, cfg.output_scale};
      default: mul_b = '0;
    endcase
  end

  always_comb begin
    prod_nxt = ctrl.mul_en ? mul_a * mul_b : prod_r;

    // accumulate, derivative term floored to q.8 then clamped
    d_sh    = prod_r >>> D_FRAC;
    acc_tot = acc_r + $signed(d_sh[ACC_W-1:0]);
    unique case (ctrl.acc_op)
      ACC_NOP:  acc_nxt = acc_r;
      ACC_LOAD: acc_nxt = prod_r[ACC_W-1:0];
      ACC_ADD:  acc_nxt = acc_r + $signed(prod_r[ACC_W-1:0]);
      ACC_ADD_SAT: begin
        if (acc_tot > SUM_LIM) begin
          acc_nxt = SUM_LIM;
        end else if (acc_tot < SUM_LIM_N) begin
          acc_nxt = SUM_LIM_N;
        end else begin
          acc_nxt = acc_tot;
        end
      end
      default:  acc_nxt = acc_r;
    endcase

    // ratio test against threshold*setpoint, no division
    lhs = {{(RAT_W-ERR_W-THR_FRAC){err_r[ERR_W-1]}}, err_r, {THR_FRAC{1'b0}}};
    rhs = {{(RAT_W-COEF_W-SAMPLE_BITS){prod_r[COEF_W+SAMPLE_BITS-1]}},
           prod_r[COEF_W+SAMPLE_BITS-1:0]};
    below_nxt = below_r;
    if (ctrl.aux_op == X_RATIO) begin
      if (sp_r == '0) begin
        below_nxt = err_r[ERR_W-1];
      end else if (sp_r[SAMPLE_BITS-1]) begin
        below_nxt = lhs > rhs;
      end else begin
        below_nxt = lhs < rhs;
      end
    end

    // round half up of the low partial product
    rnd_sum = prod_r[RND_W-1:0] + RND_HALF;
    rnd_nxt = (ctrl.aux_op == X_ROUND) ? rnd_sum[RND_W-1:SPLIT] : rnd_r;
  end

  always_comb begin
    y = prod_r + $signed({{(PROD_W-RES_LO_W){1'b0}}, rnd_r});
    res.channel_out = ch_r;
    if (y > DRV_MAX) begin
      res.drive   = DRV_MAX[SAMPLE_BITS-1:0];
      res.clipped = 1'b1;
    end else if (y < DRV_MIN) begin
      res.drive   = DRV_MIN[SAMPLE_BITS-1:0];
      res.clipped = 1'b1;
    end else begin
      res.drive   = y[SAMPLE_BITS-1:0];
      res.clipped = 1'b0;
    end

    integ_on = !cfg.integ_gain[COEF_W-1] && (cfg.integ_gain != '0);
    sum_ext  = {sum_r[SUM_W-1], sum_r}
             + {{(SUM_W+1-ERR_W){err_r[ERR_W-1]}}, err_r};
    if (!(integ_on && below_r)) begin
      sum_new = '0;
    end else if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
      sum_new = sum_ext[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_new = sum_ext[SUM_W-1:0];
    end

    st_wr.en  = step_en && (ctrl.aux_op == X_FINISH);
    st_wr.ch  = ch_r[CH_IDX_W-1:0];
    st_wr.sum = sum_new;
    st_wr.err = err_r;
  end

endmodule

`default_nettype wire

// ===== sv/pid_conditional_integral_unit.sv =====
// six-loop pid position controller with conditional integration
//
// in_ch carries one sample per transfer: loop index, setpoint and measurement.
// out_ch returns one drive value per in-range sample, tagged with its loop
// index and a flag that is set when the value hit the signed 16-bit limits.
// samples naming a loop index of six or above are taken and dropped silently.
// cfg_we/cfg_index/cfg_data write the six gain and scale registers; writes to
// indexes six and seven are ignored. write them only while the block is idle.
//
// the result is registered at the program's final step; when the derivative gain
// is zero the program skips the derivative scaling step.
// a new sample is taken only after the running program ends; a microprogram of
// 8 steps drives one shared 34x17 multiplier, one product per step but the last.
// reset (synchronous, active low) loads the default gains, clears each loop's
// error sum and last error, and empties the result register.
// when the receiver stalls, the finished result waits in the output register;
// the next sample is still taken and worked on, and only its final step waits
// for the register to free up.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pid_conditional_integral_unit (
  input  wire                            clk,
  input  wire                            rst_n,
  pci_in_if.sink                         in_ch,
  pci_out_if.source                      out_ch,
  input  wire                            cfg_we,
  input  wire [pci_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [pci_pkg::CFG_W-1:0]       cfg_data
);
  import pci_pkg::*;

  // configuration registers
  cfg_t cfg_r;

  // sequencer / datapath links
  ctrl_word_t              ctrl;
  logic                    step_en;
  logic                    busy;
  logic                    in_xfer;
  logic                    start;
  logic                    fin;
  logic                    out_free;
  logic                    dgain_zero;
  res_t                    res;
  st_wr_t                  st_wr;
  logic signed [SUM_W-1:0] rd_sum;
  logic signed [ERR_W-1:0] rd_err;

  // result register
  logic                    out_valid_r;
  res_t                    out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain         <= RST_PROP_GAIN;
      cfg_r.integ_gain        <= RST_INTEG_GAIN;
      cfg_r.deriv_gain        <= RST_DERIV_GAIN;
      cfg_r.inv_sample_period <= RST_INV_PERIOD;
      cfg_r.ratio_threshold   <= RST_RATIO_THR;
      cfg_r.output_scale      <= RST_OUT_SCALE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PROP_GAIN:  cfg_r.prop_gain         <= cfg_data;
        REG_INTEG_GAIN: cfg_r.integ_gain        <= cfg_data;
        REG_DERIV_GAIN: cfg_r.deriv_gain        <= cfg_data;
        REG_INV_PERIOD: cfg_r.inv_sample_period <= cfg_data;
        REG_RATIO_THR:  cfg_r.ratio_threshold   <= cfg_data;
        REG_OUT_SCALE:  cfg_r.output_scale      <= cfg_data;
        default: ;
      endcase
    end
  end

  // input side: take a sample whenever no program runs
  assign in_ch.ready = !busy;
  assign in_xfer     = in_ch.valid && in_ch.ready;
  // only loops that exist start a program
  assign start       = in_xfer && (in_ch.channel < CH_W'(CHANNELS));
  assign dgain_zero  = (cfg_r.deriv_gain == '0);

  // result register frees up on the same edge as its transfer
  assign out_free    = !out_valid_r || out_ch.ready;
  assign fin         = step_en && ctrl.last;

  pci_sequencer u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .dgain_zero (dgain_zero),
    .out_free   (out_free),
    .ctrl       (ctrl),
    .step_en    (step_en),
    .busy       (busy)
  );

  pci_loop_state u_state (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_ch  (in_ch.channel),
    .rd_sum (rd_sum),
    .rd_err (rd_err),
    .wr     (st_wr)
  );

  pci_datapath u_dp (
    .clk         (clk),
    .start       (start),
    .in_channel  (in_ch.channel),
    .in_setpoint (in_ch.setpoint),
    .in_measured (in_ch.measured),
    .rd_sum      (rd_sum),
    .rd_err      (rd_err),
    .cfg         (cfg_r),
    .ctrl        (ctrl),
    .step_en     (step_en),
    .res         (res),
    .st_wr       (st_wr)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.channel_out = out_res_r.channel_out;
  assign out_ch.drive       = out_res_r.drive;
  assign out_ch.clipped     = out_res_r.clipped;

  `ASSERT_RST(a_out_from_fin, clk, rst_n, $rose(out_valid_r) |-> $past(fin), "result appeared without a finished program")

endmodule

`default_nettype wire

// ===== tb/sv/pid_conditional_integral_unit_test.sv =====
`timescale 1ns / 1ps

module pid_conditional_integral_unit_test;
  import pci_pkg::*;

  // register indexes past the end of the list, writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 3'd7;

  // loop indexes that the block takes and drops
  localparam logic [CH_W-1:0] CH_DROP_LO = CH_W'(CHANNELS);
  localparam logic [CH_W-1:0] CH_DROP_HI = '1;

  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = 16'sh8000;

  localparam int SETTLE_CYCLES = 24;      // covers a full program plus a dropped sample
  localparam int CYCLE_LIMIT   = 200000;
  localparam int MAX_GAP       = 12;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  pci_in_if in_if ();
  pci_out_if out_if ();

  pid_conditional_integral_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the gain registers
  logic signed [COEF_W-1:0] k_prop, k_integ, k_deriv, k_ratio;
  logic        [COEF_W-1:0] k_inv_period, k_out_scale;

  // shadow copy of each loop's state
  logic signed [SUM_W-1:0] integ_sum [CHANNELS];
  logic signed [ERR_W-1:0] prev_err  [CHANNELS];

  // drive values still owed by the block, oldest first
  res_t pending_drives[$];

  int  mismatch_count;
  int  cycle_count;
  bit  in_steady;          // sender offers back to back when set
  bit  out_steady;         // receiver never stalls when set
  int unsigned stall_request;  // long receiver hold-off, picked up by the sink process
  bit  result_taken;

  // next drive value of one loop, and the loop's state update
  function automatic res_t next_drive(input logic [CH_W-1:0] ch,
                                      input logic signed [SAMPLE_BITS-1:0] sp_v,
                                      input logic signed [SAMPLE_BITS-1:0] ms_v);
    longint sp, err, delta, p_term, i_term, d_term, acc, y, lhs, rhs, nsum, lim;
    longint pg, ig, dg, ip, th, sc;
    bit below, clip;
    res_t r;
    pg = k_prop;
    ig = k_integ;
    dg = k_deriv;
    ip = k_inv_period;
    th = k_ratio;
    sc = k_out_scale;
    sp = sp_v;
    err = sp - longint'(ms_v);
    delta = err - longint'(prev_err[ch]);

    // p and i are Q.8, d is Q.16 floored to Q.8
    p_term = pg * err;
    i_term = ig * longint'(integ_sum[ch]);
    d_term = (dg * delta * ip) >>> 8;
    lim = longint'(1) <<< SUM_LIM_EXP;
    acc = p_term + i_term + d_term;
    if (acc > lim) acc = lim;
    if (acc < -lim) acc = -lim;

    // scale to Q.24 and round half up
    y = (acc * sc + (longint'(1) <<< 23)) >>> 24;
    clip = 1'b0;
    if (y > longint'(S_MAX)) begin
      y = S_MAX;
      clip = 1'b1;
    end
    if (y < longint'(S_MIN)) begin
      y = S_MIN;
      clip = 1'b1;
    end

    // error/setpoint below the threshold, sign of the setpoint flips the compare
    lhs = err * 4096;
    rhs = th * sp;
    if (sp > 0) below = (lhs < rhs);
    else if (sp < 0) below = (lhs > rhs);
    else below = (err < 0);

    if (ig > 0 && below) begin
      nsum = longint'(integ_sum[ch]) + err;
      if (nsum > 64'sd2147483647) nsum = 64'sd2147483647;
      if (nsum < -64'sd2147483648) nsum = -64'sd2147483648;
      integ_sum[ch] = nsum[SUM_W-1:0];
    end else begin
      integ_sum[ch] = '0;
    end
    prev_err[ch] = err[ERR_W-1:0];

    r.channel_out = ch;
    r.drive = y[SAMPLE_BITS-1:0];
    r.clipped = clip;
    return r;
  endfunction

  function automatic int unsigned pick_gap(input bit steady);
    return steady ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // one sample transfer, prediction made when the block takes it
  task automatic send_sample(input logic [CH_W-1:0] ch,
                             input logic signed [SAMPLE_BITS-1:0] sp,
                             input logic signed [SAMPLE_BITS-1:0] ms);
    int unsigned gap;
    gap = pick_gap(in_steady);
    @(negedge clk);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.channel  <= ch;
    in_if.setpoint <= sp;
    in_if.measured <= ms;
    do @(posedge clk); while (!in_if.ready);
    if (ch < CHANNELS) pending_drives.push_back(next_drive(ch, sp, ms));
  endtask

  // drop valid, wait for every owed drive value and let the block finish
  task automatic settle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_PROP_GAIN:  k_prop       = data;
      REG_INTEG_GAIN: k_integ      = data;
      REG_DERIV_GAIN: k_deriv      = data;
      REG_INV_PERIOD: k_inv_period = data;
      REG_RATIO_THR:  k_ratio      = data;
      REG_OUT_SCALE:  k_out_scale  = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_gains(input logic [CFG_W-1:0] pg, input logic [CFG_W-1:0] ig,
                            input logic [CFG_W-1:0] dg, input logic [CFG_W-1:0] ip,
                            input logic [CFG_W-1:0] th, input logic [CFG_W-1:0] sc);
    write_reg(REG_PROP_GAIN, pg);
    write_reg(REG_INTEG_GAIN, ig);
    write_reg(REG_DERIV_GAIN, dg);
    write_reg(REG_INV_PERIOD, ip);
    write_reg(REG_RATIO_THR, th);
    write_reg(REG_OUT_SCALE, sc);
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] pick_extreme();
    case ($urandom_range(0, 3))
      0: return S_MIN;
      1: return S_MAX;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  // full 16-bit value half the time, a small signed one otherwise
  function automatic logic [CFG_W-1:0] pick_gain();
    logic [CFG_W-1:0] v;
    int g;
    if ($urandom_range(0, 1) == 0) begin
      v = CFG_W'($urandom);
    end else begin
      g = int'($urandom_range(0, 1024)) - 512;
      v = g[CFG_W-1:0];
    end
    return v;
  endfunction

  // random sample, mostly near the setpoint so that integration engages
  task automatic send_random_sample(output bit counted);
    logic [CH_W-1:0] ch;
    logic signed [SAMPLE_BITS-1:0] sp, ms;
    int unsigned kind;
    int tmp;
    kind = $urandom_range(0, 99);
    ch = CH_W'($urandom_range(0, CHANNELS - 1));
    sp = SAMPLE_BITS'($urandom);
    ms = SAMPLE_BITS'($urandom);
    if (kind < 5) begin
      ch = CH_W'($urandom_range(CHANNELS, (1 << CH_W) - 1));
    end else if (kind < 15) begin
      sp = pick_extreme();
      ms = pick_extreme();
    end else if (kind >= 40) begin
      if (kind >= 92) sp = '0;
      tmp = int'(sp) - int'($urandom_range(0, 400)) + 200;
      if (tmp > 32767) tmp = 32767;
      if (tmp < -32768) tmp = -32768;
      ms = tmp[SAMPLE_BITS-1:0];
    end
    send_sample(ch, sp, ms);
    counted = (ch < CHANNELS);
  endtask

  // defaults straight out of reset: unity gain, extremes clip, dropped loop indexes
  task automatic test_default_gains();
    send_sample(3'd0, 16'sd0, 16'sd0);
    send_sample(3'd1, S_MAX, S_MIN);
    send_sample(3'd2, S_MIN, S_MAX);
    send_sample(3'd3, S_MIN, S_MIN);
    send_sample(CH_DROP_LO, 16'sd1234, -16'sd77);
    send_sample(3'd4, S_MAX, S_MAX);
    send_sample(CH_DROP_HI, S_MAX, S_MIN);
    send_sample(3'd5, 16'sd1000, 16'sd990);
  endtask

  // ratio test on each side of zero, the equality boundary, and zero setpoint
  task automatic test_integration_window();
    settle();
    write_reg(REG_INTEG_GAIN, 16'd256);
    send_sample(3'd0, 16'sd1000, 16'sd900);
    send_sample(3'd0, 16'sd1000, 16'sd900);
    send_sample(3'd0, 16'sd100, 16'sd0);       // error equals setpoint, sum clears
    send_sample(3'd0, -16'sd1000, -16'sd900);
    send_sample(3'd0, -16'sd1000, -16'sd900);
    send_sample(3'd1, 16'sd0, 16'sd5);         // zero setpoint, negative error integrates
    send_sample(3'd1, 16'sd0, 16'sd5);
    send_sample(3'd1, 16'sd0, -16'sd5);        // zero setpoint, positive error clears
    settle();
    write_reg(REG_INTEG_GAIN, 16'hFF00);       // negative gain turns integration off
    send_sample(3'd2, 16'sd1000, 16'sd900);
  endtask

  // every register at an extreme, plus writes past the end of the list
  task automatic test_extreme_gains();
    settle();
    load_gains(16'h8000, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'h8000, 16'hFFFF);
    write_reg(REG_UNUSED_A, 16'h1234);
    write_reg(REG_UNUSED_B, 16'hFFFF);
    send_sample(3'd1, 16'sd100, S_MAX);
    send_sample(3'd1, 16'sd100, S_MAX);
    send_sample(3'd1, S_MIN, S_MAX);
    settle();
    load_gains(16'h7FFF, 16'h0001, 16'h8000, 16'h0000, 16'h7FFF, 16'h0000);
    send_sample(3'd2, S_MAX, S_MIN);
    settle();
    write_reg(REG_OUT_SCALE, 16'h0001);
    send_sample(3'd3, S_MIN, S_MAX);
  endtask

  // receiver holds off while samples keep coming, then the sender waits for all
  task automatic test_back_pressure();
    settle();
    load_gains(16'd256, 16'd64, 16'd128, 16'd256, 16'd4096, 16'd32768);
    in_steady = 1'b1;
    stall_request = 150;
    repeat (12) send_sample(CH_W'($urandom_range(0, CHANNELS - 1)),
                            SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom));
    in_steady = 1'b0;
    settle();
  endtask

  // random gains per phase, extremes in the first two, idling varied per phase
  task automatic test_random_phases();
    int taken;
    bit counted;
    for (int phase = 0; phase < 8; phase++) begin
      settle();
      if (phase == 0) begin
        load_gains(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'h7FFF, 16'hFFFF);
      end else if (phase == 1) begin
        load_gains(16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h8000, 16'h0000);
      end else begin
        load_gains(pick_gain(), ($urandom_range(0, 3) == 0) ? pick_gain()
                   : 16'($urandom_range(1, 2048)),
                   pick_gain(), CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
      end
      in_steady  = (phase == 2 || phase == 5);
      out_steady = (phase == 3 || phase == 5);
      taken = 0;
      while (taken < 52) begin
        send_random_sample(counted);
        if (counted) taken++;
      end
    end
    in_steady  = 1'b0;
    out_steady = 1'b0;
  endtask

  // receiver: fresh stall drawn after each transfer, long hold-off on request
  initial begin : result_sink
    int unsigned wait_left;
    out_if.ready = 1'b0;
    wait_left = 0;
    forever begin
      @(negedge clk);
      if (result_taken) begin
        result_taken = 1'b0;
        wait_left = pick_gap(out_steady);
      end
      if (stall_request > wait_left) wait_left = stall_request;
      stall_request = 0;
      if (wait_left != 0) begin
        out_if.ready <= 1'b0;
        wait_left--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // compare each transfer with the oldest owed drive value
  always @(posedge clk) begin
    res_t exp_r;
    if (rst_n && out_if.valid && out_if.ready) begin
      result_taken = 1'b1;
      if (pending_drives.size() == 0) begin
        $display("%0t: unexpected result, channel %0d drive %0d clipped %0b",
                 $time, out_if.channel_out, out_if.drive, out_if.clipped);
        mismatch_count++;
      end else begin
        exp_r = pending_drives.pop_front();
        if (out_if.channel_out !== exp_r.channel_out) begin
          $display("%0t: channel_out mismatch, expected %0d, actual %0d",
                   $time, exp_r.channel_out, out_if.channel_out);
          mismatch_count++;
        end
        if (out_if.drive !== exp_r.drive) begin
          $display("%0t: drive mismatch on channel %0d, expected %0d, actual %0d",
                   $time, exp_r.channel_out, exp_r.drive, out_if.drive);
          mismatch_count++;
        end
        if (out_if.clipped !== exp_r.clipped) begin
          $display("%0t: clipped mismatch on channel %0d, expected %0b, actual %0b",
                   $time, exp_r.channel_out, exp_r.clipped, out_if.clipped);
          mismatch_count++;
        end
      end
    end
  end

  // hang guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_if.valid    = 1'b0;
    in_if.channel  = '0;
    in_if.setpoint = '0;
    in_if.measured = '0;
    mismatch_count = 0;
    cycle_count    = 0;
    in_steady      = 1'b0;
    out_steady     = 1'b0;
    stall_request  = 0;
    result_taken   = 1'b0;
    k_prop         = RST_PROP_GAIN;
    k_integ        = RST_INTEG_GAIN;
    k_deriv        = RST_DERIV_GAIN;
    k_inv_period   = RST_INV_PERIOD;
    k_ratio        = RST_RATIO_THR;
    k_out_scale    = RST_OUT_SCALE;
    for (int i = 0; i < CHANNELS; i++) begin
      integ_sum[i] = '0;
      prev_err[i]  = '0;
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_default_gains();
    test_integration_window();
    test_extreme_gains();
    test_back_pressure();
    test_random_phases();

    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_drives.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
